// File: rtl/attack_shape_hit_test_unit_assert.svh
// assertion macros shared by the attack shape hit test rtl
// no dependencies; included by modules that carry assertions
`ifndef ATTACK_SHAPE_HIT_TEST_UNIT_ASSERT_SVH
`define ATTACK_SHAPE_HIT_TEST_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ASHT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("asht check failed");

// next-cycle implication, disabled during reset
`define ASHT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("asht check failed");

`endif

// File: rtl/asht_pkg.sv
// shared types and constants for the attack shape hit test
// no dependencies
`default_nettype none

package asht_pkg;

  // pipeline depth from accept to result register
  localparam int unsigned NumStages = 10;
  localparam int unsigned NumTrig   = 7;

  // quarter-wave sine polynomial, q14
  localparam logic [14:0] SinA        = 15'd25736;
  localparam logic [13:0] SinB        = 14'd10512;
  localparam logic [10:0] SinC        = 11'd1160;
  localparam logic [15:0] QuarterTurn = 16'd16384;
  localparam logic [14:0] QuarterZ    = 15'd16384;

  // shape kinds; the last code is unused and never hits
  typedef enum logic [1:0] {
    ACT_CIRCLE = 2'd0,
    ACT_RECT   = 2'd1,
    ACT_SECTOR = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // one input item
  typedef struct packed {
    logic [1:0]         action;
    logic signed [23:0] shape_x;
    logic signed [23:0] shape_z;
    logic [15:0]        shape_radius;
    logic [15:0]        half_width;
    logic [15:0]        half_length;
    logic [15:0]        rotation;
    logic [15:0]        half_angle;
    logic signed [23:0] target_x;
    logic signed [23:0] target_z;
    logic [15:0]        target_radius;
    logic [7:0]         target_tag;
  } item_t;

  // per-item values that ride beside the trig lanes
  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        hw;
    logic [15:0]        hl;
    logic [15:0]        tr;
    logic               ha_big;
    logic [7:0]         tag;
    logic signed [24:0] dx;
    logic signed [24:0] dz;
    logic [48:0]        dd;
    logic [33:0]        rs;
    logic [39:0]        r12sq;
  } side_t;

  // sine and cosine values, q2.14
  typedef struct packed {
    logic signed [15:0] s;
    logic signed [15:0] c;
    logic signed [15:0] s1;
    logic signed [15:0] c1;
    logic signed [15:0] s2;
    logic signed [15:0] c2;
    logic signed [15:0] ch;
  } trig_t;

endpackage

`default_nettype wire

// File: rtl/asht_if.sv
// valid/ready channel interfaces for input items and result items
// depends on asht_pkg
`default_nettype none

interface asht_in_if import asht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [23:0] shape_x;
  logic signed [23:0] shape_z;
  logic [15:0]        shape_radius;
  logic [15:0]        half_width;
  logic [15:0]        half_length;
  logic [15:0]        rotation;
  logic [15:0]        half_angle;
  logic signed [23:0] target_x;
  logic signed [23:0] target_z;
  logic [15:0]        target_radius;
  logic [7:0]         target_tag;

  modport source (
    output valid, action, shape_x, shape_z, shape_radius, half_width, half_length,
           rotation, half_angle, target_x, target_z, target_radius, target_tag,
    input  ready
  );
  modport sink (
    input  valid, action, shape_x, shape_z, shape_radius, half_width, half_length,
           rotation, half_angle, target_x, target_z, target_radius, target_tag,
    output ready
  );
endinterface

interface asht_out_if import asht_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       hit;
  logic [7:0] result_tag;

  modport source (output valid, hit, result_tag, input ready);
  modport sink (input valid, hit, result_tag, output ready);
endinterface

`default_nettype wire

// File: rtl/asht_sin.sv
// pipelined binary-angle sine, five register stages, one multiply in each but the first
// depends on asht_pkg
`default_nettype none

module asht_sin import asht_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [15:0] value
);

  logic [14:0] z_in;
  logic [14:0] z0, z1, z2, z3;
  logic        n0, n1, n2, n3;
  logic [14:0] zz1, zz2;
  logic [13:0] t2;
  logic [14:0] u3;
  logic [29:0] sq;
  logic [25:0] pc;
  logic [28:0] pt;
  logic [29:0] pv;
  logic signed [15:0] v_pos;

  // fold the angle into the first quadrant
  assign z_in = angle[14] ? (QuarterZ - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};

  assign sq    = z0 * z0;
  assign pc    = zz1 * SinC;
  assign pt    = zz2 * t2;
  assign pv    = z3 * u3;
  assign v_pos = $signed(pv[29:14]);

  // polynomial steps
  always_ff @(posedge clk) begin
    if (en) begin
      z0 <= z_in;
      n0 <= angle[15];
      z1  <= z0;
      zz1 <= sq[28:14];
      n1  <= n0;
      z2  <= z1;
      zz2 <= zz1;
      t2  <= SinB - {2'b00, pc[25:14]};
      n2  <= n1;
      z3 <= z2;
      u3 <= SinA - pt[28:14];
      n3 <= n2;
      value <= n3 ? -v_pos : v_pos;
    end
  end

endmodule

`default_nettype wire

// File: rtl/asht_front.sv
// offsets, squared distance and squared radius sums, stages one to five
// depends on asht_pkg
`default_nettype none

module asht_front import asht_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  item_t item,
  output side_t side
);

  logic signed [24:0] dx_next, dz_next;
  logic signed [24:0] dx1, dz1, dx2, dz2;
  logic [15:0] sr1, tr1, hw1, hl1, tr2, hw2, hl2;
  logic        hab1, hab2;
  logic [1:0]  act1, act2;
  logic [7:0]  tag1, tag2;
  logic signed [24:0] dx_neg, dz_neg;
  logic [23:0] dx_mag, dz_mag;
  logic [16:0] rsum;
  logic [19:0] r12;
  logic [47:0] dxsq2, dzsq2;
  logic [33:0] rs2;
  logic [39:0] r12sq2;
  side_t s3, s4;

  assign dx_next = $signed({item.target_x[23], item.target_x})
                 - $signed({item.shape_x[23], item.shape_x});
  assign dz_next = $signed({item.target_z[23], item.target_z})
                 - $signed({item.shape_z[23], item.shape_z});

  assign dx_neg = -dx1;
  assign dz_neg = -dz1;
  assign dx_mag = dx1[24] ? dx_neg[23:0] : dx1[23:0];
  assign dz_mag = dz1[24] ? dz_neg[23:0] : dz1[23:0];
  assign rsum   = {1'b0, sr1} + {1'b0, tr1};
  assign r12    = {tr1, 4'b0000};

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offsets
      dx1  <= dx_next;
      dz1  <= dz_next;
      sr1  <= item.shape_radius;
      tr1  <= item.target_radius;
      hw1  <= item.half_width;
      hl1  <= item.half_length;
      hab1 <= item.half_angle[15];
      act1 <= item.action;
      tag1 <= item.target_tag;
      // stage 2: squares
      dxsq2  <= dx_mag * dx_mag;
      dzsq2  <= dz_mag * dz_mag;
      rs2    <= rsum * rsum;
      r12sq2 <= r12 * r12;
      dx2  <= dx1;
      dz2  <= dz1;
      tr2  <= tr1;
      hw2  <= hw1;
      hl2  <= hl1;
      hab2 <= hab1;
      act2 <= act1;
      tag2 <= tag1;
      // stage 3: squared distance
      s3.action <= act2;
      s3.hw     <= hw2;
      s3.hl     <= hl2;
      s3.tr     <= tr2;
      s3.ha_big <= hab2;
      s3.tag    <= tag2;
      s3.dx     <= dx2;
      s3.dz     <= dz2;
      s3.dd     <= {1'b0, dxsq2} + {1'b0, dzsq2};
      s3.rs     <= rs2;
      s3.r12sq  <= r12sq2;
      // stages 4 and 5: wait for the trig lanes
      s4   <= s3;
      side <= s4;
    end
  end

endmodule

`default_nettype wire

// File: rtl/asht_back.sv
// frame rotation, clamping, angular and edge tests, stages six to ten
// depends on asht_pkg
`default_nettype none

module asht_back import asht_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  side_t      side,
  input  trig_t      trig,
  output logic       hit,
  output logic [7:0] tag
);

  // excess beyond [-half, half] in q22, rounded half up to q12
  function automatic logic [31:0] excess_q12(input logic signed [41:0] v,
                                             input logic [15:0] half);
    logic signed [42:0] vv;
    logic signed [42:0] lim;
    logic signed [42:0] e;
    logic [42:0]        er;
    vv = {v[41], v};
    lim = $signed({13'b0, half, 14'b0});
    e = '0;
    if (vv > lim) begin
      e = vv - lim;
    end else if (vv < -lim) begin
      e = -lim - vv;
    end
    er = e + 43'd512;
    return er[41:10];
  endfunction

  side_t b6, b7, b8, b9;
  logic signed [31:0] ch_sq;
  logic signed [40:0] dxc6, dzs6, dxs6, dzc6;
  logic signed [40:0] dxs16, dzc16, dzs16, dxc16;
  logic signed [40:0] dxs26, dzc26, dzs26, dxc26;
  logic [28:0] chsq6;
  logic        chneg6, chneg7, chneg8, chneg9;
  logic signed [41:0] lx7, lz7, d1_7, d2_7, x1_7, x2_7;
  logic [53:0] qlo7;
  logic [52:0] qhi7;
  logic signed [41:0] lz_neg, cross_sel, cross_neg;
  logic [40:0] p_mag;
  logic [41:0] c_mag;
  logic [31:0] ex8, ez8;
  logic [41:0] hh8;
  logic [40:0] hl8;
  logic [39:0] ll8;
  logic [78:0] qq8;
  logic [63:0] qq9;
  logic        edge8, edge9, pneg8, pneg9;
  logic [63:0] pp9;
  logic [63:0] ex2_9, ez2_9;
  logic        rect_hit, circ_hit, circ_near, outside, hit_next;

  assign ch_sq = trig.ch * trig.ch;

  // stage 6: products with the trig values
  always_ff @(posedge clk) begin
    if (en) begin
      b6     <= side;
      dxc6   <= side.dx * trig.c;
      dzs6   <= side.dz * trig.s;
      dxs6   <= side.dx * trig.s;
      dzc6   <= side.dz * trig.c;
      dxs16  <= side.dx * trig.s1;
      dzc16  <= side.dz * trig.c1;
      dzs16  <= side.dz * trig.s1;
      dxc16  <= side.dx * trig.c1;
      dxs26  <= side.dx * trig.s2;
      dzc26  <= side.dz * trig.c2;
      dzs26  <= side.dz * trig.s2;
      dxc26  <= side.dx * trig.c2;
      chsq6  <= ch_sq[28:0];
      chneg6 <= trig.ch[15];
    end
  end

  // stage 7: rotated offsets, edge dots and crosses, cos^2 times distance^2
  always_ff @(posedge clk) begin
    if (en) begin
      b7     <= b6;
      lx7    <= {dxc6[40], dxc6} - {dzs6[40], dzs6};
      lz7    <= {dxs6[40], dxs6} + {dzc6[40], dzc6};
      d1_7   <= {dxs16[40], dxs16} + {dzc16[40], dzc16};
      d2_7   <= {dxs26[40], dxs26} + {dzc26[40], dzc26};
      x1_7   <= {dzs16[40], dzs16} - {dxc16[40], dxc16};
      x2_7   <= {dzs26[40], dzs26} - {dxc26[40], dxc26};
      qlo7   <= chsq6 * b6.dd[24:0];
      qhi7   <= chsq6 * b6.dd[48:25];
      chneg7 <= chneg6;
    end
  end

  assign lz_neg    = -lz7;
  assign p_mag     = lz7[41] ? lz_neg[40:0] : lz7[40:0];
  assign cross_sel = (d1_7 >= d2_7) ? x1_7 : x2_7;
  assign cross_neg = -cross_sel;
  assign c_mag     = cross_sel[41] ? cross_neg : cross_sel;

  // stage 8: clamp excess, partial squares of the forward dot, nearer edge
  always_ff @(posedge clk) begin
    if (en) begin
      b8     <= b7;
      ex8    <= excess_q12(lx7, b7.hw);
      ez8    <= excess_q12(lz7, b7.hl);
      hh8    <= p_mag[40:20] * p_mag[40:20];
      hl8    <= p_mag[40:20] * p_mag[19:0];
      ll8    <= p_mag[19:0] * p_mag[19:0];
      qq8    <= {1'b0, qhi7, 25'b0} + {25'b0, qlo7};
      edge8  <= c_mag <= {12'b0, b7.tr, 14'b0};
      pneg8  <= lz7[41];
      chneg8 <= chneg7;
    end
  end

  // stage 9: squares; the angular test squares wrap at 64 bits
  always_ff @(posedge clk) begin
    if (en) begin
      b9     <= b8;
      pp9    <= {hh8[23:0], 40'b0} + {2'b00, hl8, 21'b0} + {24'b0, ll8};
      ex2_9  <= ex8 * ex8;
      ez2_9  <= ez8 * ez8;
      qq9    <= qq8[63:0];
      edge9  <= edge8;
      pneg9  <= pneg8;
      chneg9 <= chneg8;
    end
  end

  assign rect_hit  = ({1'b0, ex2_9} + {1'b0, ez2_9}) < {25'b0, b9.r12sq};
  assign circ_hit  = b9.dd < {15'b0, b9.rs};
  assign circ_near = b9.dd <= {15'b0, b9.rs};

  // outside the half angle, decided by signs and squares
  always_comb begin
    priority if (pneg9 && !chneg9) begin
      outside = 1'b1;
    end else if (!pneg9 && chneg9) begin
      outside = 1'b0;
    end else if (!pneg9) begin
      outside = pp9 < qq9;
    end else begin
      outside = pp9 > qq9;
    end
  end

  always_comb begin
    unique case (action_t'(b9.action))
      ACT_CIRCLE: hit_next = circ_hit;
      ACT_RECT:   hit_next = rect_hit;
      ACT_SECTOR: hit_next = circ_near && (b9.ha_big || !outside || edge9);
      default:    hit_next = 1'b0;
    endcase
  end

  // stage 10: result register
  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_next;
      tag <= b9.tag;
    end
  end

endmodule

`default_nettype wire

// File: rtl/attack_shape_hit_test_unit.sv
// Attack shape hit test: one shape/target pair per item, one result item per input
// item, in order. The pipeline is ten register stages deep, and a new item can be
// accepted every cycle unless the pipeline is frozen. The depth is set by the
// five-step sine polynomial feeding the rotation products and the split wide
// squares of the sector test. When a result is held because the sink is not
// ready, the whole pipeline freezes and input ready drops.
// depends on asht_pkg, asht_if, asht_sin, asht_front, asht_back
`default_nettype none

`include "attack_shape_hit_test_unit_assert.svh"

module attack_shape_hit_test_unit import asht_pkg::*; (
  input logic         clk,
  input logic         rst,
  asht_in_if.sink     shape_in,
  asht_out_if.source  result_out
);

  logic                 adv;
  logic [NumStages-1:0] vld;
  item_t                item;
  side_t                side;
  trig_t                trig;
  logic [15:0]          ang [NumTrig];
  logic signed [15:0]   tv  [NumTrig];
  logic [15:0]          rot_p, rot_m;

  // pipeline advances unless the result register is held
  assign adv = !vld[NumStages-1] || result_out.ready;
  assign shape_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NumStages-2:0], shape_in.valid};
    end
  end

  assign item = '{
    action:        shape_in.action,
    shape_x:       shape_in.shape_x,
    shape_z:       shape_in.shape_z,
    shape_radius:  shape_in.shape_radius,
    half_width:    shape_in.half_width,
    half_length:   shape_in.half_length,
    rotation:      shape_in.rotation,
    half_angle:    shape_in.half_angle,
    target_x:      shape_in.target_x,
    target_z:      shape_in.target_z,
    target_radius: shape_in.target_radius,
    target_tag:    shape_in.target_tag
  };

  // angles for the trig lanes
  assign rot_p  = shape_in.rotation + shape_in.half_angle;
  assign rot_m  = shape_in.rotation - shape_in.half_angle;
  assign ang[0] = shape_in.rotation;
  assign ang[1] = shape_in.rotation + QuarterTurn;
  assign ang[2] = rot_p;
  assign ang[3] = rot_p + QuarterTurn;
  assign ang[4] = rot_m;
  assign ang[5] = rot_m + QuarterTurn;
  assign ang[6] = shape_in.half_angle + QuarterTurn;

  for (genvar i = 0; i < NumTrig; i++) begin : g_trig
    asht_sin u_sin (
      .clk   (clk),
      .en    (adv),
      .angle (ang[i]),
      .value (tv[i])
    );
  end

  assign trig = '{s: tv[0], c: tv[1], s1: tv[2], c1: tv[3], s2: tv[4], c2: tv[5],
                  ch: tv[6]};

  asht_front u_front (
    .clk  (clk),
    .en   (adv),
    .item (item),
    .side (side)
  );

  asht_back u_back (
    .clk  (clk),
    .en   (adv),
    .side (side),
    .trig (trig),
    .hit  (result_out.hit),
    .tag  (result_out.result_tag)
  );

  assign result_out.valid = vld[NumStages-1];

  // checks
  `ASHT_NEXT(a_accept_enters, clk, rst, shape_in.valid && shape_in.ready, vld[0])
  `ASHT_NEXT(a_stall_freezes, clk, rst, !adv, vld == $past(vld))
  `ASHT_HOLDS(a_full_blocks, clk, rst, vld[NumStages-1] && !result_out.ready, !shape_in.ready)
  `ASHT_NEXT(a_drain_empties, clk, rst, result_out.valid && result_out.ready && !vld[NumStages-2], !result_out.valid)

endmodule

`default_nettype wire
